// File: rtl/dpg_pkg.sv
// ----------------------------------------------------------------------------
// dpg_pkg
// Shared types and constants for the dipole potential grid evaluator.
// ----------------------------------------------------------------------------
package dpg_pkg;

  localparam int MAX_DIPOLES_DEF = 64;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_EVAL   = 2'd2;

  // iteration counts of the shared serial units
  localparam int MUL_ITER   = 35;   // multiplier bits (34-bit root, zero-extended)
  localparam int SQRT_ITER  = 34;   // root bits of a 68-bit radicand
  localparam int DIV_ITER   = 115;  // numerator bits: 67-bit |dot| << 48
  localparam int FRAC_SHIFT = 48;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_READ, S_DIFF, S_MINIT, S_MSTEP, S_MACC,
    S_SQINIT, S_SQSTEP, S_DINIT, S_DSTEP, S_VINIT, S_VSTEP, S_ACC, S_OUT
  } ctl_state_t;

  typedef enum logic [3:0] {
    OP_NOP, OP_CLEAR, OP_APPEND, OP_START, OP_READ, OP_DIFF,
    OP_MUL_INIT, OP_MUL_STEP, OP_MUL_ACC, OP_SQRT_INIT, OP_SQRT_STEP,
    OP_DEN_INIT, OP_DIV_INIT, OP_DIV_STEP, OP_ACC, OP_SING
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [2:0] k;     // product select: axis = k/2, odd k squares d
    logic       emit;  // load the result register
  } dp_ctl_t;

  typedef struct packed {
    logic all_done;   // index reached the dipole count
    logic step_last;  // serial unit on its final step
    logic n2_zero;    // point coincides with the dipole site
  } dp_sts_t;

endpackage

// File: rtl/dpg_ctrl.sv
// ----------------------------------------------------------------------------
// dpg_ctrl
// Sequencer: accepts commands and walks the datapath through each dipole term.
// ----------------------------------------------------------------------------
module dpg_ctrl
  import dpg_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] in_cmd,
  output logic       busy,
  output dp_ctl_t    ctl,
  input  dp_sts_t    sts
);

  ctl_state_t state_r, state_nxt;
  logic [2:0] k_r, k_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    ctl.op    = OP_NOP;
    ctl.k     = k_r;
    ctl.emit  = 1'b0;
    busy      = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (in_cmd)
            CMD_CLEAR:  ctl.op = OP_CLEAR;
            CMD_APPEND: ctl.op = OP_APPEND;
            CMD_EVAL: begin
              ctl.op    = OP_START;
              state_nxt = S_CHECK;
            end
            default: ;  // unused code: ignored
          endcase
        end
      end
      S_CHECK:  state_nxt = sts.all_done ? S_OUT : S_READ;
      S_READ: begin
        ctl.op    = OP_READ;
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        ctl.op    = OP_DIFF;
        k_nxt     = '0;
        state_nxt = S_MINIT;
      end
      S_MINIT: begin
        ctl.op    = OP_MUL_INIT;
        state_nxt = S_MSTEP;
      end
      S_MSTEP: begin
        ctl.op = OP_MUL_STEP;
        if (sts.step_last) state_nxt = S_MACC;
      end
      S_MACC: begin
        ctl.op = OP_MUL_ACC;
        if (k_r == 3'd5) state_nxt = S_SQINIT;
        else begin
          k_nxt     = k_r + 3'd1;
          state_nxt = S_MINIT;
        end
      end
      S_SQINIT: begin
        if (sts.n2_zero) begin
          ctl.op    = OP_SING;
          state_nxt = S_CHECK;
        end else begin
          ctl.op    = OP_SQRT_INIT;
          state_nxt = S_SQSTEP;
        end
      end
      S_SQSTEP: begin
        ctl.op = OP_SQRT_STEP;
        if (sts.step_last) state_nxt = S_DINIT;
      end
      S_DINIT: begin
        ctl.op    = OP_DEN_INIT;
        state_nxt = S_DSTEP;
      end
      S_DSTEP: begin
        ctl.op = OP_MUL_STEP;
        if (sts.step_last) state_nxt = S_VINIT;
      end
      S_VINIT: begin
        ctl.op    = OP_DIV_INIT;
        state_nxt = S_VSTEP;
      end
      S_VSTEP: begin
        ctl.op = OP_DIV_STEP;
        if (sts.step_last) state_nxt = S_ACC;
      end
      S_ACC: begin
        ctl.op    = OP_ACC;
        state_nxt = S_CHECK;
      end
      S_OUT: begin
        ctl.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// File: rtl/dpg_datapath.sv
// ----------------------------------------------------------------------------
// dpg_datapath
// Dipole table memory, serial multiplier, root and divider, wide accumulator.
// ----------------------------------------------------------------------------
module dpg_datapath
  import dpg_pkg::*;
#(
  parameter int MAX_DIPOLES = MAX_DIPOLES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_ctl_t            ctl,
  output dp_sts_t            sts,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [31:0] in_moment_x,
  input  logic signed [31:0] in_moment_y,
  input  logic signed [31:0] in_moment_z,
  output logic               out_valid,
  output logic signed [63:0] out_potential,
  output logic               out_saturated,
  output logic               out_singular
);

  localparam int CW = $clog2(MAX_DIPOLES + 1);
  localparam int AW = (MAX_DIPOLES > 1) ? $clog2(MAX_DIPOLES) : 1;

  logic [191:0] mem [MAX_DIPOLES];
  logic [191:0] rd_r;

  logic [CW-1:0] count_r, idx_r;
  logic [31:0]   pt_r [3];
  logic [32:0]   dm_r [3];
  logic [31:0]   pm_r [3];
  logic [2:0]    dn_r, pn_r;
  logic          sgn_r;

  logic [101:0]  mcand_r, prod_r;
  logic [34:0]   mplier_r;
  logic [6:0]    cnt_r;

  logic signed [67:0] dot_r;
  logic [66:0]   n2_r;
  logic [67:0]   rad_r;
  logic [36:0]   rem_r;
  logic [33:0]   root_r;

  logic [114:0]  divq_r;
  logic [101:0]  drem_r, den_r;
  logic signed [127:0] acc_r;
  logic          sing_r;

  logic [1:0]    ax;
  logic [36:0]   sq_t, sq_trial;
  logic [102:0]  dv_t;
  logic [66:0]   dot_mag;
  logic          hi_same;

  assign ax       = ctl.k[2:1];
  assign sq_t     = {rem_r[34:0], rad_r[67:66]};
  assign sq_trial = {1'b0, root_r, 2'b01};
  assign dv_t     = {drem_r, divq_r[114]};
  assign dot_mag  = dot_r[67] ? 67'(-dot_r) : 67'(dot_r);
  assign hi_same  = (acc_r[127:63] == '0) || (acc_r[127:63] == '1);

  assign sts.all_done  = (idx_r == count_r);
  assign sts.step_last = (cnt_r == '0);
  assign sts.n2_zero   = (n2_r == '0);

  // table write and registered read
  always_ff @(posedge clk) begin
    if (ctl.op == OP_APPEND && count_r < CW'(MAX_DIPOLES))
      mem[count_r[AW-1:0]] <= {in_moment_z, in_moment_y, in_moment_x,
                               in_pos_z, in_pos_y, in_pos_x};
    if (ctl.op == OP_READ) rd_r <= mem[idx_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= ctl.emit;
      if (ctl.op == OP_CLEAR) count_r <= '0;
      else if (ctl.op == OP_APPEND && count_r < CW'(MAX_DIPOLES))
        count_r <= count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      OP_START: begin
        pt_r[0] <= in_pos_x;
        pt_r[1] <= in_pos_y;
        pt_r[2] <= in_pos_z;
        idx_r   <= '0;
        acc_r   <= '0;
        sing_r  <= 1'b0;
      end
      OP_DIFF: begin
        for (int a = 0; a < 3; a++) begin
          logic signed [32:0] d;
          logic [31:0]        p;
          d = {pt_r[a][31], pt_r[a]} - {rd_r[32*a+31], rd_r[32*a +: 32]};
          p = rd_r[96+32*a +: 32];
          dm_r[a] <= d[32] ? 33'(-d) : 33'(d);
          dn_r[a] <= d[32];
          pm_r[a] <= p[31] ? -p : p;
          pn_r[a] <= p[31];
        end
        dot_r <= '0;
        n2_r  <= '0;
      end
      OP_MUL_INIT: begin
        mcand_r  <= 102'(dm_r[ax]);
        mplier_r <= ctl.k[0] ? 35'(dm_r[ax]) : 35'(pm_r[ax]);
        sgn_r    <= dn_r[ax] ^ pn_r[ax];
        prod_r   <= '0;
        cnt_r    <= 7'(MUL_ITER - 1);
      end
      OP_MUL_STEP: begin
        if (mplier_r[0]) prod_r <= prod_r + mcand_r;
        mcand_r  <= {mcand_r[100:0], 1'b0};
        mplier_r <= {1'b0, mplier_r[34:1]};
        cnt_r    <= cnt_r - 7'd1;
      end
      OP_MUL_ACC: begin
        if (ctl.k[0]) n2_r <= n2_r + prod_r[66:0];
        else if (sgn_r) dot_r <= dot_r - $signed({1'b0, prod_r[66:0]});
        else dot_r <= dot_r + $signed({1'b0, prod_r[66:0]});
      end
      OP_SQRT_INIT: begin
        rad_r  <= {1'b0, n2_r};
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= 7'(SQRT_ITER - 1);
      end
      OP_SQRT_STEP: begin
        if (sq_t >= sq_trial) begin
          rem_r  <= sq_t - sq_trial;
          root_r <= {root_r[32:0], 1'b1};
        end else begin
          rem_r  <= sq_t;
          root_r <= {root_r[32:0], 1'b0};
        end
        rad_r <= {rad_r[65:0], 2'b00};
        cnt_r <= cnt_r - 7'd1;
      end
      OP_DEN_INIT: begin
        mcand_r  <= 102'(n2_r);
        mplier_r <= 35'(root_r);
        prod_r   <= '0;
        cnt_r    <= 7'(MUL_ITER - 1);
      end
      OP_DIV_INIT: begin
        den_r  <= prod_r;
        divq_r <= {dot_mag, FRAC_SHIFT'(0)};
        drem_r <= '0;
        cnt_r  <= 7'(DIV_ITER - 1);
      end
      OP_DIV_STEP: begin
        if (dv_t >= {1'b0, den_r}) begin
          drem_r <= 102'(dv_t - {1'b0, den_r});
          divq_r <= {divq_r[113:0], 1'b1};
        end else begin
          drem_r <= dv_t[101:0];
          divq_r <= {divq_r[113:0], 1'b0};
        end
        cnt_r <= cnt_r - 7'd1;
      end
      OP_ACC: begin
        if (dot_r[67]) acc_r <= acc_r - $signed({13'd0, divq_r});
        else acc_r <= acc_r + $signed({13'd0, divq_r});
        idx_r <= idx_r + CW'(1);
      end
      OP_SING: begin
        sing_r <= 1'b1;
        idx_r  <= idx_r + CW'(1);
      end
      default: ;
    endcase
  end

  // clamp to Q16.48 once at the end
  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_singular  <= sing_r;
      out_saturated <= !hi_same;
      if (hi_same) out_potential <= acc_r[63:0];
      else if (acc_r[127]) out_potential <= {1'b1, 63'd0};
      else out_potential <= {1'b0, {63{1'b1}}};
    end
  end

endmodule

// File: rtl/dipole_potential_on_grid.sv
// ----------------------------------------------------------------------------
// dipole_potential_on_grid
// Point dipole table with evaluation of the summed dipolar potential.
// ----------------------------------------------------------------------------
// Clear and append leave busy low, so the next command may follow at once.
// Evaluate holds busy over all N stored dipoles: each term runs seven 35-step
// multiplies, a 34-step root and a 115-step divide, and a coincident dipole
// stops after the first six multiplies. out_valid pulses for one cycle, the
// cycle busy drops, and cannot be stalled. Synchronous active-low reset
// empties the table and idles the sequencer; table contents are not cleared.
module dipole_potential_on_grid
  import dpg_pkg::*;
#(
  parameter int MAX_DIPOLES = MAX_DIPOLES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_cmd,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [31:0] in_moment_x,
  input  logic signed [31:0] in_moment_y,
  input  logic signed [31:0] in_moment_z,
  output logic               out_valid,
  output logic signed [63:0] out_potential,
  output logic               out_saturated,
  output logic               out_singular
);

  dp_ctl_t ctl;  // per-cycle datapath command
  dp_sts_t sts;  // loop and unit status back to the sequencer

  dpg_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_cmd),
    .busy   (busy),
    .ctl    (ctl),
    .sts    (sts)
  );

  dpg_datapath #(.MAX_DIPOLES(MAX_DIPOLES)) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .sts           (sts),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_pos_z      (in_pos_z),
    .in_moment_x   (in_moment_x),
    .in_moment_y   (in_moment_y),
    .in_moment_z   (in_moment_z),
    .out_valid     (out_valid),
    .out_potential (out_potential),
    .out_saturated (out_saturated),
    .out_singular  (out_singular)
  );

endmodule

// File: rtl/dpg_checker.sv
// ----------------------------------------------------------------------------
// dpg_checker
// Port-level checks on command acceptance and result strobes.
// ----------------------------------------------------------------------------
module dpg_checker
  import dpg_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [1:0]  in_cmd,
  input logic        out_valid,
  input logic [63:0] out_potential,
  input logic        out_saturated
);

  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_cmd == CMD_EVAL |=> busy)
    else $error("evaluate accepted but busy not raised");

  a_strobe_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && $past(busy))
    else $error("result outside an evaluation");

  a_sat_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      out_potential == 64'h7fff_ffff_ffff_ffff ||
      out_potential == 64'h8000_0000_0000_0000)
    else $error("saturated result not clamped");

endmodule

bind dipole_potential_on_grid dpg_checker u_dpg_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_cmd        (in_cmd),
  .out_valid     (out_valid),
  .out_potential (out_potential),
  .out_saturated (out_saturated)
);

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for dipole_potential_on_grid: drives clear, append,
// evaluate and unused commands and checks every potential against a local
// predictor of the dipole table and the summed dipolar potential.
// ----------------------------------------------------------------------------
module testbench;
  import dpg_pkg::*;

  localparam int    TABLE_DEPTH = MAX_DIPOLES_DEF;
  localparam int    CYCLE_LIMIT = 40000000;
  // unused command code, ignored by the block
  localparam logic [1:0] CMD_NONE = 2'd3;
  // drain margin, a little over one full-table evaluation
  localparam int    DRAIN_CYCLES = 2 + TABLE_DEPTH * 420;

  // --------------------------------------------------------------------------
  // Scoreboard: keeps its own copy of the dipole table, predicts the result
  // of each accepted evaluate and checks results in order.
  // --------------------------------------------------------------------------
  class potential_scoreboard;
    logic signed [31:0] sx[TABLE_DEPTH], sy[TABLE_DEPTH], sz[TABLE_DEPTH];
    logic signed [31:0] mx[TABLE_DEPTH], my[TABLE_DEPTH], mz[TABLE_DEPTH];
    int                 count;
    logic [65:0]        expected_q[$];  // {potential, saturated, singular}
    int                 errors;

    function new();
      count  = 0;
      errors = 0;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    // (r-s).p/|r-s|^3 for one stored dipole, in Q16.48, truncated to zero
    function automatic logic signed [127:0] dipole_term(
      int i, logic signed [31:0] rx, ry, rz, output bit coincident);
      logic signed [127:0] dx, dy, dz, dot;
      logic [127:0]        n2, root, cand, num, den, q;
      dx = 128'(rx) - 128'(sx[i]);
      dy = 128'(ry) - 128'(sy[i]);
      dz = 128'(rz) - 128'(sz[i]);
      dot = dx * 128'(mx[i]) + dy * 128'(my[i]) + dz * 128'(mz[i]);
      n2 = dx * dx + dy * dy + dz * dz;
      coincident = (n2 == 0);
      if (coincident) return 0;
      root = 0;
      for (int k = 34; k >= 0; k--) begin
        cand = root | (128'd1 << k);
        if (cand * cand <= n2) root = cand;
      end
      num = (dot < 0) ? 128'(-dot) : 128'(dot);
      num = num << FRAC_SHIFT;
      den = n2 * root;
      q = num / den;
      return (dot < 0) ? -$signed(q) : $signed(q);
    endfunction

    function void note_item(logic [1:0] cmd, logic signed [31:0] px, py, pz,
                            logic signed [31:0] qx, qy, qz);
      logic signed [127:0] acc;
      logic signed [63:0]  pot;
      bit                  sing, sat, hit;
      case (cmd)
        CMD_CLEAR: count = 0;
        CMD_APPEND: begin
          if (count < TABLE_DEPTH) begin
            sx[count] = px; sy[count] = py; sz[count] = pz;
            mx[count] = qx; my[count] = qy; mz[count] = qz;
            count++;
          end
        end
        CMD_EVAL: begin
          acc  = 0;
          sing = 0;
          for (int i = 0; i < count; i++) begin
            acc = acc + dipole_term(i, px, py, pz, hit);
            sing |= hit;
          end
          sat = 1;
          if (acc > 128'sh7fff_ffff_ffff_ffff) pot = 64'sh7fff_ffff_ffff_ffff;
          else if (acc < -128'sh8000_0000_0000_0000) pot = 64'sh8000_0000_0000_0000;
          else begin
            pot = acc[63:0];
            sat = 0;
          end
          expected_q.push_back({pot, sat, sing});
        end
        default: ;  // unused command: no effect
      endcase
    endfunction

    task check(logic signed [63:0] pot, logic sat, logic sing);
      logic [65:0] e;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result pot=%h", pot));
        return;
      end
      e = expected_q.pop_front();
      if (pot !== e[65:2])
        report($sformatf("potential got %h exp %h", pot, e[65:2]));
      if (sat !== e[1]) report($sformatf("saturated got %b exp %b", sat, e[1]));
      if (sing !== e[0]) report($sformatf("singular got %b exp %b", sing, e[0]));
    endtask
  endclass

  logic               clk, rst_n, start, busy;
  logic [1:0]         in_cmd;
  logic signed [31:0] in_pos_x, in_pos_y, in_pos_z;
  logic signed [31:0] in_moment_x, in_moment_y, in_moment_z;
  logic               out_valid, out_saturated, out_singular;
  logic signed [63:0] out_potential;

  potential_scoreboard sb = new();
  int                  cycles = 0;
  int                  idle_pct = 0;  // sender idle chance per item, percent
  logic signed [31:0]  last_x = 0, last_y = 0, last_z = 0;  // last site

  dipole_potential_on_grid dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // results are one-cycle strobes; sampled before the edge updates them
  always @(posedge clk)
    if (rst_n && out_valid) sb.check(out_potential, out_saturated, out_singular);

  // Issue one item: hold start until an edge with busy low takes it, then
  // maybe drop start and idle before returning.
  task send_item(logic [1:0] cmd, logic signed [31:0] px, py, pz, qx, qy, qz);
    start       <= 1'b1;
    in_cmd      <= cmd;
    in_pos_x    <= px;  in_pos_y    <= py;  in_pos_z    <= pz;
    in_moment_x <= qx;  in_moment_y <= qy;  in_moment_z <= qz;
    do @(posedge clk); while (busy);
    sb.note_item(cmd, px, py, pz, qx, qy, qz);
    if (cmd == CMD_APPEND) begin
      last_x = px; last_y = py; last_z = pz;
    end
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
    end
  endtask

  // coordinate: full range, tiny, extreme, or close to the last site
  function automatic logic signed [31:0] pick_coord(logic signed [31:0] near);
    case ($urandom_range(3))
      0: return $urandom;
      1: return $signed($urandom_range(8)) - 4;
      2: return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      default: return near + $signed($urandom_range(6)) - 3;
    endcase
  endfunction

  function automatic logic signed [31:0] pick_moment();
    case ($urandom_range(3))
      0: return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      1: return $signed($urandom_range(1 << 17)) - (1 << 16);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int          r;
    logic [1:0]  cmd;
    logic signed [31:0] px, py, pz;
    rst_n = 0; start = 0; in_cmd = CMD_CLEAR;
    in_pos_x = 0; in_pos_y = 0; in_pos_z = 0;
    in_moment_x = 0; in_moment_y = 0; in_moment_z = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, extremes, coincident point, saturation both ways
    send_item(CMD_EVAL, 0, 0, 0, 0, 0, 0);
    send_item(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
    send_item(CMD_APPEND, 32'sh7fff_ffff, 32'sh8000_0000, 0,
              32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
    send_item(CMD_EVAL, 32'sh7fff_ffff, 32'sh8000_0000, 0, 0, 0, 0);
    send_item(CMD_EVAL, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 0, 0, 0);
    send_item(CMD_NONE, 1, 2, 3, 4, 5, 6);
    send_item(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
    send_item(CMD_APPEND, 0, 0, 0, 32'sh7fff_ffff, 0, 0);
    send_item(CMD_EVAL, 1, 0, 0, 0, 0, 0);
    send_item(CMD_EVAL, -1, 0, 0, 0, 0, 0);
    send_item(CMD_EVAL, 32'sh0001_0000, 32'sh0001_0000, 0, 0, 0, 0);
    send_item(CMD_EVAL, 0, 0, 0, 0, 0, 0);
    send_item(CMD_APPEND, 0, 0, 32'sh0002_0000, 0, 0, 32'sh8000_0000);
    send_item(CMD_EVAL, 0, 0, 1, 0, 0, 0);
    // full table: the append past the end must be dropped
    send_item(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
    for (int i = 0; i <= TABLE_DEPTH; i++)
      send_item(CMD_APPEND, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom);
    send_item(CMD_EVAL, last_x, last_y, last_z, 0, 0, 0);
    send_item(CMD_EVAL, $urandom, $urandom, $urandom, 0, 0, 0);
    send_item(CMD_CLEAR, 0, 0, 0, 0, 0, 0);

    // random: short tables so evaluations stay cheap, idling varies by phase
    for (int n = 0; n < 210; n++) begin
      case (n * 4 / 210)
        0: idle_pct = 0;
        1: idle_pct = 79;
        2: idle_pct = 15;
        default: idle_pct = 0;
      endcase
      r = $urandom_range(99);
      if (r < 8) cmd = CMD_CLEAR;
      else if (r < 55) cmd = CMD_APPEND;
      else if (r < 95) cmd = CMD_EVAL;
      else cmd = CMD_NONE;
      if (cmd == CMD_EVAL && $urandom_range(4) == 0) begin
        px = last_x; py = last_y; pz = last_z;  // coincident with a site
      end else begin
        px = pick_coord(last_x); py = pick_coord(last_y); pz = pick_coord(last_z);
      end
      send_item(cmd, px, py, pz, pick_moment(), pick_moment(), pick_moment());
    end
    start <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
